// ===== rtl/double_word_integer_alu_macros.svh =====
// Assertion macros used by the checker file dwa_checker.sv.
`ifndef DOUBLE_WORD_INTEGER_ALU_MACROS_SVH
`define DOUBLE_WORD_INTEGER_ALU_MACROS_SVH

// Implication checked only while reset is low.
`define DWA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked at every edge, reset included.
`define DWA_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// A stalled transaction must keep its payload on the next edge.
`define DWA_ASSERT_HOLD(label, valid, ready, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) \
    ((valid) && !(ready)) |=> $stable(sig)) else $error(msg);

`endif

// ===== rtl/dwa_pkg.sv =====
package dwa_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned NARROW_W  = 32;
  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned DIV_STEPS = 64;

  // Opcodes as they arrive on the slave side.
  localparam logic [OPCODE_W-1:0] OP_ADD_NARROW = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SUB_NARROW = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_ADD_WIDE   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_MUL_NARROW = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DIV_NARROW = 3'd4;

  // Operation classes handed from the front end to the execution pipeline.
  localparam int unsigned KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUB  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MUL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV  = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] first;
    logic [WORD_W-1:0] second;
  } op_item_t;

  typedef struct packed {
    logic                valid;
    logic [KIND_W-1:0]   kind;
    logic [WORD_W-1:0]   acc;
    logic [NARROW_W-1:0] rem;
    logic [NARROW_W-1:0] divisor;
    logic                dz;
  } stage_t;

endpackage

// ===== rtl/dwa_front.sv =====
module dwa_front #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [159:0]                         s_tdata,
  input  logic [dwa_pkg::OPCODE_W-1:0]         s_tuser,
  output logic                                 head_valid,
  output dwa_pkg::op_item_t                    head_item,
  input  logic                                 head_pop
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  dwa_pkg::op_item_t item_in;
  dwa_pkg::op_item_t mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              push;

  // Classify the opcode and line up the second operand for the back end.
  always_comb begin
    item_in.first = s_tdata[63:0];
    unique case (s_tuser)
      dwa_pkg::OP_ADD_NARROW: begin
        item_in.kind   = dwa_pkg::KIND_ADD;
        item_in.second = {32'd0, s_tdata[159:128]};
      end
      dwa_pkg::OP_SUB_NARROW: begin
        item_in.kind   = dwa_pkg::KIND_SUB;
        item_in.second = {32'd0, s_tdata[159:128]};
      end
      dwa_pkg::OP_ADD_WIDE: begin
        item_in.kind   = dwa_pkg::KIND_ADD;
        item_in.second = s_tdata[127:64];
      end
      dwa_pkg::OP_MUL_NARROW: begin
        item_in.kind   = dwa_pkg::KIND_MUL;
        item_in.second = {32'd0, s_tdata[159:128]};
      end
      dwa_pkg::OP_DIV_NARROW: begin
        item_in.kind   = dwa_pkg::KIND_DIV;
        item_in.second = {32'd0, s_tdata[159:128]};
      end
      default: begin
        item_in.kind   = dwa_pkg::KIND_NONE;
        item_in.second = '0;
      end
    endcase
  end

  assign s_tready   = (count != CNT_W'(QUEUE_DEPTH));
  assign push       = s_tvalid && s_tready;
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];

  always_comb begin
    case ({push, head_pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (head_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/dwa_back.sv =====
module dwa_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  dwa_pkg::op_item_t            head_item,
  output logic                         head_pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [dwa_pkg::WORD_W-1:0]   m_tdata,
  output logic [0:0]                   m_tuser
);

  // Stage 0 computes, stage 1 finishes the multiply, then one stage per quotient bit.
  localparam int unsigned NSTAGE = dwa_pkg::DIV_STEPS + 2;

  dwa_pkg::stage_t pipe [NSTAGE];
  dwa_pkg::stage_t nxt  [NSTAGE];
  logic            advance;
  logic [63:0]     prod_lo;
  logic [31:0]     prod_hi;

  // One restoring step: shift in the next dividend bit and shift a quotient bit into acc.
  function automatic dwa_pkg::stage_t div_step(input dwa_pkg::stage_t s);
    dwa_pkg::stage_t r;
    logic [32:0]     shifted;
    logic [32:0]     diff;
    logic            ge;
    r       = s;
    shifted = {s.rem, s.acc[63]};
    diff    = shifted - {1'b0, s.divisor};
    ge      = (shifted >= {1'b0, s.divisor});
    if (s.kind == dwa_pkg::KIND_DIV) begin
      r.rem = ge ? diff[31:0] : shifted[31:0];
      r.acc = {s.acc[62:0], ge};
    end
    return r;
  endfunction

  assign advance  = !pipe[NSTAGE-1].valid || m_tready;
  assign head_pop = advance && head_valid;

  assign prod_lo = {32'd0, head_item.first[31:0]} * {32'd0, head_item.second[31:0]};
  assign prod_hi = head_item.first[63:32] * head_item.second[31:0];

  always_comb begin
    nxt[0].valid   = head_valid;
    nxt[0].kind    = head_item.kind;
    nxt[0].divisor = head_item.second[31:0];
    nxt[0].dz      = 1'b0;
    nxt[0].rem     = '0;
    unique case (head_item.kind)
      dwa_pkg::KIND_ADD: nxt[0].acc = head_item.first + head_item.second;
      dwa_pkg::KIND_SUB: nxt[0].acc = head_item.first - head_item.second;
      dwa_pkg::KIND_MUL: begin
        nxt[0].acc = prod_lo;
        nxt[0].rem = prod_hi;
      end
      dwa_pkg::KIND_DIV: nxt[0].acc = head_item.first;
      default:           nxt[0].acc = '0;
    endcase

    nxt[1] = pipe[0];
    if (pipe[0].kind == dwa_pkg::KIND_MUL) begin
      nxt[1].acc = pipe[0].acc + {pipe[0].rem, 32'd0};
      nxt[1].rem = '0;
    end
    if (pipe[0].kind == dwa_pkg::KIND_DIV) begin
      nxt[1].dz = (pipe[0].divisor == '0);
    end

    for (int unsigned k = 2; k < NSTAGE; k++) begin
      nxt[k] = div_step(pipe[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int unsigned k = 0; k < NSTAGE; k++) begin
      if (rst) begin
        pipe[k].valid <= 1'b0;
      end else if (advance) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  assign m_tvalid   = pipe[NSTAGE-1].valid;
  assign m_tdata    = pipe[NSTAGE-1].acc;
  assign m_tuser[0] = pipe[NSTAGE-1].dz;

endmodule

// ===== rtl/double_word_integer_alu.sv =====
// Throughput: one transaction per cycle in steady state for every operation, while m_tready accepts results.
// The divide retires one quotient bit per pipeline stage over 64 stages.
// Reset (rst, synchronous, active high) empties the queue and clears all stage valid bits;
// no clearing pass follows.
module double_word_integer_alu #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  // Slave side: operation requests.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,  // first_value[63:0], second_wide[127:64], second_narrow[159:128]
  input  logic [2:0]   s_tuser,  // opcode[2:0]
  // Master side: results.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // result_value[63:0]
  output logic [0:0]   m_tuser   // divide_by_zero[0]
);

  // The front end decodes the opcode, selects the second operand and buffers
  // the transaction in a small queue, so the slave side keeps flowing while
  // the master side stalls until the queue fills.
  logic              head_valid;
  logic              head_pop;
  dwa_pkg::op_item_t head_item;

  dwa_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_pop   (head_pop)
  );

  // The back end is a fixed-length pipeline that every operation walks
  // through, which keeps results in order. Adds and subtracts finish in the
  // first stage, the multiply in the second (two partial products, then a
  // shifted add), and the divide in the 64 restoring steps after that. The
  // whole pipeline advances whenever its last stage is empty or taken.
  dwa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_pop   (head_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

// ===== rtl/dwa_checker.sv =====
`include "double_word_integer_alu_macros.svh"

module dwa_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [159:0] s_tdata,
  input logic [2:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata,
  input logic [0:0]   m_tuser
);

  `DWA_ASSERT_HOLD(a_out_hold, m_tvalid, m_tready, m_tdata, "stalled result changed")
  `DWA_ASSERT_HOLD(a_in_hold, s_tvalid, s_tready, {s_tuser, s_tdata}, "stalled request changed")
  `DWA_ASSERT_IMPL(a_dz_ones, m_tvalid && m_tuser[0], m_tdata == '1, "dz result not all ones")
  `DWA_ASSERT_ALWAYS(a_rst_out, $past(rst) && !rst, !m_tvalid, "result valid after reset")
  `DWA_ASSERT_ALWAYS(a_rst_in, $past(rst) && !rst, s_tready, "not ready right after reset")

endmodule

bind double_word_integer_alu dwa_checker u_dwa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
